// ----- rtl/hamming_leader_classifier_assert.svh -----
// assertion macros shared by the classifier rtl
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef HAMMING_LEADER_CLASSIFIER_ASSERT_SVH
`define HAMMING_LEADER_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlc check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define HLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlc check failed: next-cycle implication");

`endif

// ----- rtl/hlc_pkg.sv -----
// shared types and constants for the hamming leader classifier
// no dependencies; imported by every rtl file of the block except hlc_ram
package hlc_pkg;

  localparam int HLC_VECTOR_BITS = 3200;
  localparam int HLC_MAX_CLASSES = 256;

  localparam int WORD_W    = 64;
  localparam int THR_W     = 12;
  localparam int MOD_W     = 7;
  localparam int CHAN_W    = 7;
  localparam int RUN_W     = 20;
  localparam int IDX_W     = 8;
  localparam int BIT_W     = 14;  // 64*127+127 fits
  localparam int POP_W     = 7;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam logic [THR_W-1:0] THR_RESET = 12'd5;

  typedef enum logic {
    CMD_MARK     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } hlc_cmd_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } hlc_status_t;

  typedef enum logic {
    REG_MATCH_THRESHOLD = 1'b0
  } hlc_reg_t;

  // control from the sequencer to the distance unit
  typedef struct packed {
    logic clr;
    logic vld;
  } hlc_dist_ctl_t;

endpackage

// ----- rtl/hlc_if.sv -----
// valid/ready channel interfaces for the classifier input and result words
// depends on hlc_pkg for field widths
interface hlc_in_if import hlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [MOD_W-1:0]  module_number;
  logic [CHAN_W-1:0] channel_number;
  logic [RUN_W-1:0]  run_number;

  modport source (output valid, command, module_number, channel_number, run_number,
                  input ready);
  modport sink   (input valid, command, module_number, channel_number, run_number,
                  output ready);
endinterface

interface hlc_out_if import hlc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RUN_W-1:0] run_tag;
  logic [IDX_W-1:0] class_index;
  logic             new_class;
  logic             status;

  modport source (output valid, run_tag, class_index, new_class, status, input ready);
  modport sink   (input valid, run_tag, class_index, new_class, status, output ready);
endinterface

// ----- rtl/hlc_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module hlc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/hlc_dist.sv -----
// shared hamming distance unit: popcount of one xor word, then accumulate
// depends on hlc_pkg for the control struct and word width
module hlc_dist import hlc_pkg::*; #(
  parameter int DW = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hlc_dist_ctl_t     ctl,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [DW-1:0]     acc,
  output logic              busy
);

  function automatic logic [POP_W-1:0] pop64(logic [WORD_W-1:0] x);
    logic [POP_W-1:0] s;
    logic [3:0]       c;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      c = '0;
      for (int j = 0; j < 8; j++) begin
        c = c + 4'(x[8*i+j]);
      end
      s = s + POP_W'(c);
    end
    return s;
  endfunction

  logic [POP_W-1:0] pc_r;
  logic             pc_vld_r;
  logic [DW-1:0]    acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      pc_vld_r <= ctl.vld;
      if (ctl.clr) begin
        acc_r <= '0;
      end else if (pc_vld_r) begin
        acc_r <= acc_r + DW'(pc_r);
      end
    end
    pc_r <= pop64(a ^ b);
  end

  assign acc  = acc_r;
  assign busy = pc_vld_r;

endmodule

// ----- rtl/hlc_cfg.sv -----
// apb-style register port holding the match threshold
// depends on hlc_pkg for register codes and widths
module hlc_cfg import hlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [THR_W-1:0]  thr
);

  logic [THR_W-1:0] thr_r;
  logic [THR_W-1:0] thr_nxt;

  always_comb begin
    thr_nxt = thr_r;
    prdata  = '0;
    case (paddr[2])
      REG_MATCH_THRESHOLD: begin
        prdata = CFG_DW'(thr_r);
        if (psel && penable && pwrite) begin
          thr_nxt = pwdata[THR_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign pready = 1'b1;
  assign thr    = thr_r;

endmodule

// ----- rtl/hamming_leader_classifier.sv -----
// mark word: read the word, then write it back with the bit set; ready again after the write
// classify word: each stored class in turn is read word by word and its distance summed, until
//   one matches; else a new class is copied in if there is room; then the result is handed off;
//   WORDS = ceil(VECTOR_BITS/64); one popcount/accumulate unit and one ram read port are shared
// reset: threshold 5, class count 0, current vector cleared at once by per-word valid
//   flops; class table holds garbage until a class is stored, no clearing pass
`include "hamming_leader_classifier_assert.svh"

module hamming_leader_classifier import hlc_pkg::*; #(
  parameter int VECTOR_BITS = HLC_VECTOR_BITS,
  parameter int MAX_CLASSES = HLC_MAX_CLASSES
) (
  input  logic              clk,
  input  logic              rst_n,
  hlc_in_if.sink            in_ch,
  hlc_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int WORDS  = (VECTOR_BITS + 63) / 64;
  localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TDEPTH = MAX_CLASSES * WORDS;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int CW     = $clog2(MAX_CLASSES + 1);
  localparam int DW     = $clog2(WORDS * 64 + 1);
  localparam logic [WAW-1:0] LAST_W = WAW'(WORDS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK_WR,
    S_CMP,
    S_WAIT,
    S_COPY,
    S_COPY_END,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [WAW-1:0]    w_r, w_nxt, w_q;
  logic [CW-1:0]     cls_r, cls_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [TAW-1:0]    base_r, base_nxt;
  logic [WORDS-1:0]  cur_valid_r, cur_valid_nxt;
  logic              cur_vld_q, rd_vld_q, cp_q;
  logic [WAW-1:0]    mw_r, mw_nxt;
  logic [5:0]        mpos_r, mpos_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic              pnew_r, pnew_nxt;
  logic              pstat_r, pstat_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [RUN_W-1:0]  res_run_r, res_run_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic              res_new_r, res_new_nxt;
  logic              res_stat_r, res_stat_nxt;

  logic [THR_W-1:0]  thr;
  logic [BIT_W-1:0]  mbit;
  logic              mbit_ok;
  logic [WAW-1:0]    cur_raddr;
  logic              cur_we;
  logic [WORD_W-1:0] cur_wdata, cur_q, cur_word;
  logic [WORD_W-1:0] tbl_q;
  logic [TAW-1:0]    tbl_raddr, tbl_waddr;
  hlc_dist_ctl_t     dctl;
  logic [DW-1:0]     acc;
  logic              dbusy;
  logic              match;
  logic              load;
  logic [CW+IDX_W-1:0] cls_ext, count_ext;

  hlc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .thr     (thr)
  );

  hlc_ram #(.WIDTH(WORD_W), .DEPTH(WORDS), .AW(WAW)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (mw_r),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_q)
  );

  hlc_ram #(.WIDTH(WORD_W), .DEPTH(TDEPTH), .AW(TAW)) u_tbl_ram (
    .clk   (clk),
    .we    (cp_q),
    .waddr (tbl_waddr),
    .wdata (cur_word),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  hlc_dist #(.DW(DW)) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .a     (cur_word),
    .b     (tbl_q),
    .acc   (acc),
    .busy  (dbusy)
  );

  // words never written since the last classify read as zero
  assign cur_word  = cur_vld_q ? cur_q : '0;
  assign mbit      = BIT_W'({in_ch.module_number, 6'd0}) + BIT_W'(in_ch.channel_number);
  assign mbit_ok   = (mbit < BIT_W'(VECTOR_BITS));
  assign tbl_raddr = base_r + TAW'(w_r);
  assign tbl_waddr = base_r + TAW'(w_q);
  assign match     = ((DW+THR_W)'(acc) <= (DW+THR_W)'(thr));
  assign load      = !out_vld_r || out_ch.ready;
  assign cls_ext   = (CW+IDX_W)'(cls_r);
  assign count_ext = (CW+IDX_W)'(count_r);
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    cls_nxt       = cls_r;
    count_nxt     = count_r;
    base_nxt      = base_r;
    cur_valid_nxt = cur_valid_r;
    mw_nxt        = mw_r;
    mpos_nxt      = mpos_r;
    run_nxt       = run_r;
    pidx_nxt      = pidx_r;
    pnew_nxt      = pnew_r;
    pstat_nxt     = pstat_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    res_run_nxt   = res_run_r;
    res_idx_nxt   = res_idx_r;
    res_new_nxt   = res_new_r;
    res_stat_nxt  = res_stat_r;
    cur_raddr     = w_r;
    cur_we        = 1'b0;
    cur_wdata     = cur_word | (WORD_W'(1) << mpos_r);
    dctl.clr      = 1'b0;
    dctl.vld      = rd_vld_q;

    case (state_r)
      S_IDLE: begin
        // read the target word early so a mark finishes in the next cycle
        cur_raddr = mbit[6 +: WAW];
        if (in_ch.valid) begin
          if (in_ch.command == CMD_MARK) begin
            if (mbit_ok) begin
              mw_nxt    = mbit[6 +: WAW];
              mpos_nxt  = mbit[5:0];
              state_nxt = S_MARK_WR;
            end
          end else begin
            run_nxt  = in_ch.run_number;
            w_nxt    = '0;
            cls_nxt  = '0;
            base_nxt = '0;
            dctl.clr = 1'b1;
            state_nxt = (count_r == '0) ? S_COPY : S_CMP;
          end
        end
      end
      S_MARK_WR: begin
        cur_we             = 1'b1;
        cur_valid_nxt[mw_r] = 1'b1;
        state_nxt          = S_IDLE;
      end
      S_CMP: begin
        if (w_r == LAST_W) begin
          w_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          w_nxt = w_r + WAW'(1);
        end
      end
      S_WAIT: begin
        if (!rd_vld_q && !dbusy) begin
          if (match) begin
            pidx_nxt  = cls_ext[IDX_W-1:0];
            pnew_nxt  = 1'b0;
            pstat_nxt = STATUS_OK;
            state_nxt = S_DONE;
          end else begin
            base_nxt = base_r + TAW'(WORDS);
            if ((cls_r + CW'(1)) < count_r) begin
              cls_nxt   = cls_r + CW'(1);
              dctl.clr  = 1'b1;
              state_nxt = S_CMP;
            end else if (count_r < CW'(MAX_CLASSES)) begin
              state_nxt = S_COPY;
            end else begin
              pidx_nxt  = '0;
              pnew_nxt  = 1'b0;
              pstat_nxt = STATUS_FULL;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_COPY: begin
        if (w_r == LAST_W) begin
          w_nxt     = '0;
          state_nxt = S_COPY_END;
        end else begin
          w_nxt = w_r + WAW'(1);
        end
      end
      S_COPY_END: begin
        // last word is written this cycle
        pidx_nxt  = count_ext[IDX_W-1:0];
        pnew_nxt  = 1'b1;
        pstat_nxt = STATUS_OK;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load) begin
          out_vld_nxt   = 1'b1;
          res_run_nxt   = run_r;
          res_idx_nxt   = pidx_r;
          res_new_nxt   = pnew_r;
          res_stat_nxt  = pstat_r;
          cur_valid_nxt = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= '0;
      cls_r       <= '0;
      count_r     <= '0;
      base_r      <= '0;
      cur_valid_r <= '0;
      rd_vld_q    <= 1'b0;
      cp_q        <= 1'b0;
      cur_vld_q   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      cls_r       <= cls_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      cur_valid_r <= cur_valid_nxt;
      rd_vld_q    <= (state_r == S_CMP);
      cp_q        <= (state_r == S_COPY);
      cur_vld_q   <= (32'(cur_raddr) < WORDS) ? cur_valid_r[cur_raddr] : 1'b0;
      out_vld_r   <= out_vld_nxt;
    end
    w_q        <= w_r;
    mw_r       <= mw_nxt;
    mpos_r     <= mpos_nxt;
    run_r      <= run_nxt;
    pidx_r     <= pidx_nxt;
    pnew_r     <= pnew_nxt;
    pstat_r    <= pstat_nxt;
    res_run_r  <= res_run_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_stat_r <= res_stat_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.run_tag     = res_run_r;
  assign out_ch.class_index = res_idx_r;
  assign out_ch.new_class   = res_new_r;
  assign out_ch.status      = res_stat_r;

  // table is written only by the copy sweep
  `HLC_ASSERT_IMPL(a_tbl_write_in_copy, clk, rst_n, cp_q, (state_r == S_COPY || state_r == S_COPY_END))
  // storing a class bumps the count by one
  `HLC_ASSERT_NEXT(a_count_bump, clk, rst_n, state_r == S_COPY_END, count_r == $past(count_r) + CW'(1))
  // a full report only ever comes with a full table
  `HLC_ASSERT_IMPL(a_full_means_full, clk, rst_n, out_vld_r && res_stat_r == STATUS_FULL, count_r == CW'(MAX_CLASSES))
  // current vector is empty right after a result is handed off
  `HLC_ASSERT_NEXT(a_vector_cleared, clk, rst_n, state_r == S_DONE && load, cur_valid_r == '0)
  // a new class never shows the full status
  `HLC_ASSERT_IMPL(a_new_not_full, clk, rst_n, out_vld_r && res_new_r, res_stat_r == STATUS_OK)

endmodule

// ----- sim/hlc_classifier_check.sv -----
// scoreboard for the hamming leader classifier: mirrors marks, threshold writes and the
// class table, and compares every result word with the predicted one
// depends on hlc_pkg and the channel interfaces in hlc_if
module hlc_classifier_check import hlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  hlc_in_if                 in_ch,
  hlc_out_if                out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                waiting,
  output int                checked,
  output int                full_seen,
  output int                classes_made
);

  localparam logic [CFG_AW-1:0] THR_ADDR = CFG_AW'(4 * int'(REG_MATCH_THRESHOLD));

  typedef struct packed {
    logic [RUN_W-1:0] run_tag;
    logic [IDX_W-1:0] class_index;
    logic             new_class;
    hlc_status_t      status;
  } verdict_t;

  logic [HLC_VECTOR_BITS-1:0] dead_map;
  logic [HLC_VECTOR_BITS-1:0] leaders [HLC_MAX_CLASSES];
  int unsigned                leader_count;
  logic [THR_W-1:0]           threshold;
  verdict_t                   verdict_q [$];

  // first leader within threshold wins, else the map becomes a new leader if there is room
  function automatic verdict_t classify_run(input logic [RUN_W-1:0] run);
    verdict_t    v;
    int unsigned hit;
    bit          found;
    found = 1'b0;
    hit   = 0;
    for (int unsigned i = 0; i < leader_count && !found; i++) begin
      if ($countones(dead_map ^ leaders[i]) <= threshold) begin
        found = 1'b1;
        hit   = i;
      end
    end
    v.run_tag = run;
    if (found) begin
      v.class_index = IDX_W'(hit);
      v.new_class   = 1'b0;
      v.status      = STATUS_OK;
    end else if (leader_count < HLC_MAX_CLASSES) begin
      leaders[leader_count] = dead_map;
      v.class_index = IDX_W'(leader_count);
      v.new_class   = 1'b1;
      v.status      = STATUS_OK;
      leader_count++;
    end else begin
      v.class_index = '0;
      v.new_class   = 1'b0;
      v.status      = STATUS_FULL;
    end
    dead_map = '0;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    verdict_t    want;
    verdict_t    got;
    int unsigned pos;
    if (!rst_n) begin
      dead_map     = '0;
      leader_count = 0;
      threshold    = THR_RESET;
      verdict_q.delete();
      mismatches   = 0;
      checked      = 0;
      full_seen    = 0;
    end else begin
      // results first: a word accepted at this edge cannot be answered at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got.run_tag     = out_ch.run_tag;
        got.class_index = out_ch.class_index;
        got.new_class   = out_ch.new_class;
        got.status      = hlc_status_t'(out_ch.status);
        checked++;
        if (got.status == STATUS_FULL) full_seen++;
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("unexpected result run %05h idx %0d new %b status %b",
                               got.run_tag, got.class_index, got.new_class, got.status));
        end else begin
          want = verdict_q.pop_front();
          if (got !== want)
            flag_error($sformatf({"result mismatch: exp run %05h idx %0d new %b status %b,",
                                  " got run %05h idx %0d new %b status %b"},
                                 want.run_tag, want.class_index, want.new_class, want.status,
                                 got.run_tag, got.class_index, got.new_class, got.status));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == THR_ADDR) begin
        if (cfg_pwrite) begin
          threshold = cfg_pwdata[THR_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(threshold)) begin
          flag_error($sformatf("threshold readback: exp %0d got %h", threshold, cfg_prdata));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_CLASSIFY) begin
          verdict_q.push_back(classify_run(in_ch.run_number));
        end else begin
          pos = 64 * in_ch.module_number + in_ch.channel_number;
          if (pos < HLC_VECTOR_BITS) dead_map[pos] = 1'b1;
        end
      end
    end
    waiting      = verdict_q.size();
    classes_made = leader_count;
  end

endmodule

// ----- sim/hamming_leader_classifier_tb.sv -----
// top of the classifier testbench: clock, reset, word and apb stimulus, idling, verdict
// depends on hlc_pkg, hlc_if, the classifier rtl and hlc_classifier_check
module hamming_leader_classifier_tb;
  import hlc_pkg::*;

  localparam int STALL_LIMIT  = 200000;
  localparam int MARK_SETTLE  = 8;
  localparam int RANDOM_WORDS = 1200;
  localparam int PHASES       = 8;
  localparam int MOTIFS       = 6;
  localparam int MOTIF_MAX    = 32;
  localparam int LAST_MODULE  = HLC_VECTOR_BITS / 64 - 1;
  localparam int FILL_MARK    = HLC_VECTOR_BITS - 1;
  localparam int FILL_BASE    = HLC_VECTOR_BITS - 300;
  localparam logic [CFG_AW-1:0] THR_ADDR = CFG_AW'(4 * int'(REG_MATCH_THRESHOLD));

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int mismatches;
  int waiting;
  int checked;
  int full_seen;
  int classes_made;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int quiet_cycles   = 0;

  int unsigned motif [MOTIFS][MOTIF_MAX];
  int          motif_len [MOTIFS];

  hlc_in_if  in_ch ();
  hlc_out_if out_ch ();

  hamming_leader_classifier dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  hlc_classifier_check check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .mismatches   (mismatches),
    .waiting      (waiting),
    .checked      (checked),
    .full_seen    (full_seen),
    .classes_made (classes_made)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input hlc_cmd_t cmd, input logic [MOD_W-1:0] m,
                           input logic [CHAN_W-1:0] c, input logic [RUN_W-1:0] r);
    @(negedge clk);
    while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.module_number  <= m;
    in_ch.channel_number <= c;
    in_ch.run_number     <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // a channel number of 64 or more spills into the next module
  task automatic mark_bit(input int unsigned pos);
    if (pos >= 64 && $urandom_range(3, 0) == 0)
      send_word(CMD_MARK, MOD_W'(pos / 64 - 1), CHAN_W'(pos % 64 + 64), RUN_W'($urandom));
    else
      send_word(CMD_MARK, MOD_W'(pos / 64), CHAN_W'(pos % 64), RUN_W'($urandom));
  endtask

  // bit numbers past the end of the map
  task automatic mark_stray();
    if ($urandom_range(1, 0) == 1)
      send_word(CMD_MARK, MOD_W'($urandom_range(127, LAST_MODULE + 1)), CHAN_W'($urandom),
                RUN_W'($urandom));
    else
      send_word(CMD_MARK, MOD_W'(LAST_MODULE), CHAN_W'($urandom_range(127, 64)),
                RUN_W'($urandom));
  endtask

  task automatic classify_word();
    send_word(CMD_CLASSIFY, MOD_W'($urandom), CHAN_W'($urandom), RUN_W'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (MARK_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= THR_ADDR;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_threshold(input logic [CFG_DW-1:0] data);
    settle();
    cfg_access(1'b1, data);
    cfg_access(1'b0, '0);
  endtask

  // a known dead-channel pattern with a few drops, flips, repeats and stray marks
  task automatic motif_run();
    int p;
    p = $urandom_range(MOTIFS - 1, 0);
    for (int k = 0; k < motif_len[p]; k++) begin
      if ($urandom_range(15, 0) != 0) mark_bit(motif[p][k]);
    end
    repeat ($urandom_range(3, 0)) mark_bit($urandom_range(HLC_VECTOR_BITS - 1, 0));
    if ($urandom_range(7, 0) == 0) mark_bit(motif[p][0]);
    if ($urandom_range(7, 0) == 0) mark_stray();
    classify_word();
  endtask

  // scattered marks; sometimes left to pile into the next run
  task automatic noise_run();
    repeat ($urandom_range(6, 0)) mark_bit($urandom_range(HLC_VECTOR_BITS - 1, 0));
    if ($urandom_range(1, 0) == 1) mark_stray();
    if ($urandom_range(3, 0) != 0) classify_word();
  endtask

  initial begin
    int target;
    int gap_plan [4];
    int stall_plan [4];
    int thr_plan [PHASES];

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_MARK;
    in_ch.module_number  = '0;
    in_ch.channel_number = '0;
    in_ch.run_number     = '0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    gap_plan   = '{0, 62, 0, 18};
    stall_plan = '{0, 0, 62, 18};
    thr_plan = '{5, 0, HLC_VECTOR_BITS, 3, 12, 1, $urandom_range(40, 0), 5};
    for (int p = 0; p < MOTIFS; p++) begin
      motif_len[p] = $urandom_range(MOTIF_MAX, 1);
      for (int k = 0; k < MOTIF_MAX; k++) motif[p][k] = $urandom_range(HLC_VECTOR_BITS - 1, 0);
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: map corners, dropped and repeated marks, run number extremes
    send_word(CMD_MARK, 0, 0, 0);
    send_word(CMD_MARK, MOD_W'(LAST_MODULE), 63, '1);
    send_word(CMD_MARK, MOD_W'(LAST_MODULE + 1), 0, 0);
    send_word(CMD_MARK, '1, '1, '1);
    send_word(CMD_MARK, MOD_W'(LAST_MODULE), 64, 0);
    send_word(CMD_MARK, 0, '1, 0);
    send_word(CMD_MARK, 1, 63, 0);
    send_word(CMD_CLASSIFY, 0, 0, 0);
    send_word(CMD_CLASSIFY, '1, '1, '1);
    send_word(CMD_MARK, 0, 0, 0);
    send_word(CMD_CLASSIFY, 0, 0, 20'h5A5A5);
    set_threshold({20'hFFFFF, 12'd0});
    send_word(CMD_CLASSIFY, 0, 0, 20'hA5A5A);
    send_word(CMD_CLASSIFY, 0, 0, 1);
    send_word(CMD_MARK, 0, 0, 0);
    send_word(CMD_CLASSIFY, 0, 0, 2);
    set_threshold(HLC_VECTOR_BITS);
    for (int k = 0; k < 4; k++) mark_bit($urandom_range(HLC_VECTOR_BITS - 1, 0));
    send_word(CMD_CLASSIFY, 0, 0, 3);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_threshold(thr_plan[ph]);
      send_gap_pct   = gap_plan[ph % 4];
      recv_stall_pct = stall_plan[ph % 4];
      target = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < target) begin
        if ($urandom_range(9, 0) < 8) motif_run();
        else noise_run();
      end
    end

    // exact matching only, two-bit maps that differ from each other until the table fills
    set_threshold(0);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int j = 0; j < 300 && full_seen == 0; j++) begin
      mark_bit(FILL_MARK);
      mark_bit(FILL_BASE + j);
      classify_word();
    end

    set_threshold(3);
    recv_stall_pct = 62;
    mark_bit(FILL_MARK);
    mark_bit(FILL_BASE + 3);
    classify_word();
    for (int k = 0; k < 12; k++) mark_bit($urandom_range(HLC_VECTOR_BITS - 1, 0));
    classify_word();
    set_threshold(HLC_VECTOR_BITS);
    send_gap_pct = 18;
    classify_word();
    settle();

    $display("sent %0d words, checked %0d results, %0d classes stored",
             words_sent, checked, classes_made);
    $display("%0d results reported a full class table", full_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
